// ===== hw/rtl/radar_measurement_jacobian_macros.svh =====
// assertion macros for the jacobian rtl, used by rmj_back
`ifndef RADAR_MEASUREMENT_JACOBIAN_MACROS_SVH
`define RADAR_MEASUREMENT_JACOBIAN_MACROS_SVH

// condition implies property in the same cycle
`define RMJ_ASSERT_IMP(lbl, cond, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond) |-> (prop)) \
      else $error(msg);

// condition implies property in the next cycle
`define RMJ_ASSERT_NEXT(lbl, cond, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond) |=> (prop)) \
      else $error(msg);

`endif

// ===== hw/rtl/rmj_pkg.sv =====
package rmj_pkg;

   // fixed point and storage defaults
   localparam int RMJ_FRACTION_BITS = 16;
   localparam int RMJ_QUEUE_DEPTH   = 2;
   localparam int RMJ_QUO_W         = 32;
   localparam int RMJ_CSR_W         = 17;
   localparam logic [RMJ_CSR_W-1:0] RMJ_MIN_RANGE_SQ_RESET = 17'd66;

   // classified state word from the front end
   typedef struct packed {
      logic [31:0]        apx;
      logic [31:0]        apy;
      logic               px_neg;
      logic               py_neg;
      logic               py_pos;
      logic [63:0]        px2;
      logic [63:0]        py2;
      logic signed [63:0] prod_a;
      logic signed [63:0] prod_b;
   } front_type;

   // one jacobian result word
   typedef struct packed {
      logic signed [31:0] range_by_px;
      logic signed [31:0] range_by_py;
      logic signed [31:0] bearing_by_px;
      logic signed [31:0] bearing_by_py;
      logic signed [31:0] rate_by_px;
      logic signed [31:0] rate_by_py;
      logic               saturated;
   } result_type;

endpackage

// ===== hw/rtl/rmj_queue.sv =====
module rmj_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wdata,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rdata,
   output logic             empty
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             do_push, do_pop;

   // status
   assign full    = (cnt_ff == CNT_W'(DEPTH));
   assign empty   = (cnt_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = mem_ff[rd_ptr_ff];

   // pointer and count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

// ===== hw/rtl/rmj_front.sv =====
module rmj_front import rmj_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   input  logic signed [31:0] req_pos_x,
   input  logic signed [31:0] req_pos_y,
   input  logic signed [31:0] req_vel_x,
   input  logic signed [31:0] req_vel_y,
   output logic               req_full,
   output front_type          q_word,
   output logic               q_push,
   input  logic               q_full
);

   front_type front_ff, front_in;
   logic      front_vld_ff, front_vld_in;
   logic      accept;
   logic [31:0] px_bits, py_bits;

   // handshake: hold the word while the queue is full
   assign req_full     = front_vld_ff && q_full;
   assign accept       = req_push && !req_full;
   assign q_push       = front_vld_ff && !q_full;
   assign front_vld_in = accept || (front_vld_ff && q_full);
   assign q_word       = front_ff;

   assign px_bits = req_pos_x;
   assign py_bits = req_pos_y;

   // signs, magnitudes and the four products
   always_comb begin
      front_in.px_neg = req_pos_x[31];
      front_in.py_neg = req_pos_y[31];
      front_in.py_pos = !req_pos_y[31] && (req_pos_y != '0);
      front_in.apx    = req_pos_x[31] ? (~px_bits + 32'd1) : px_bits;
      front_in.apy    = req_pos_y[31] ? (~py_bits + 32'd1) : py_bits;
      front_in.px2    = 64'(front_in.apx) * 64'(front_in.apx);
      front_in.py2    = 64'(front_in.apy) * 64'(front_in.apy);
      front_in.prod_a = 64'(req_vel_x) * 64'(req_pos_y);
      front_in.prod_b = 64'(req_vel_y) * 64'(req_pos_x);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_vld_ff <= 1'b0;
      end else begin
         front_vld_ff <= front_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         front_ff <= front_in;
      end
   end

endmodule

// ===== hw/rtl/rmj_div.sv =====
module rmj_div import rmj_pkg::*; #(
   parameter int NUM_W = 48,
   parameter int DEN_W = 32
) (
   input  logic                 clock,
   input  logic                 enable,
   input  logic [NUM_W-1:0]     num,
   input  logic [DEN_W-1:0]     den,
   output logic [RMJ_QUO_W-1:0] quo,
   output logic                 ovf
);

   localparam int Q_W   = RMJ_QUO_W;
   localparam int HI_W  = NUM_W - Q_W;
   localparam int CMP_W = (HI_W > DEN_W) ? HI_W : DEN_W;

   logic [DEN_W-1:0] rem_ff [Q_W];
   logic [DEN_W-1:0] den_ff [Q_W];
   logic [Q_W-1:0]   lq_ff  [Q_W+1];
   logic             ovf_ff [Q_W+1];
   logic [HI_W-1:0]  num_hi;
   logic             ovf_in;

   // quotient too wide for the result when the upper part reaches the divisor
   assign num_hi = num[NUM_W-1:Q_W];
   assign ovf_in = (CMP_W'(num_hi) >= CMP_W'(den));

   always_ff @(posedge clock) begin
      if (enable) begin
         rem_ff[0] <= DEN_W'(num_hi);
         lq_ff[0]  <= num[Q_W-1:0];
         den_ff[0] <= den;
         ovf_ff[0] <= ovf_in;
      end
   end

   // one quotient bit per stage, low dividend bits shift out as quotient shifts in
   for (genvar j = 1; j <= Q_W; j++) begin : g_step
      logic [DEN_W:0] trial;
      logic [DEN_W:0] diff;
      logic           ge;

      assign trial = {rem_ff[j-1], lq_ff[j-1][Q_W-1]};
      assign diff  = trial - {1'b0, den_ff[j-1]};
      assign ge    = (trial >= {1'b0, den_ff[j-1]});

      always_ff @(posedge clock) begin
         if (enable) begin
            lq_ff[j]  <= {lq_ff[j-1][Q_W-2:0], ge};
            ovf_ff[j] <= ovf_ff[j-1];
         end
      end

      if (j < Q_W) begin : g_rem
         always_ff @(posedge clock) begin
            if (enable) begin
               rem_ff[j] <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
               den_ff[j] <= den_ff[j-1];
            end
         end
      end
   end

   assign quo = lq_ff[Q_W];
   assign ovf = ovf_ff[Q_W];

endmodule

// ===== hw/rtl/rmj_back.sv =====
`include "radar_measurement_jacobian_macros.svh"

module rmj_back import rmj_pkg::*; #(
   parameter int FRACTION_BITS = RMJ_FRACTION_BITS
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [RMJ_CSR_W-1:0] min_range_sq,
   input  front_type            q_word,
   input  logic                 q_empty,
   output logic                 q_pop,
   output result_type           res_word,
   output logic                 res_push,
   input  logic                 res_full
);

   localparam int SQ_STAGES  = 32;
   localparam int DIV_STAGES = RMJ_QUO_W + 1;
   localparam int LAT        = 1 + SQ_STAGES + 2 + DIV_STAGES;

   typedef struct packed {
      logic [63:0] s;
      logic [63:0] dmag;
      logic [31:0] apx;
      logic [31:0] apy;
      logic [5:0]  neg;
   } ctx_type;

   typedef struct packed {
      logic [31:0] r;
      logic [63:0] s;
      logic [31:0] apx;
      logic [31:0] apy;
      logic [5:0]  neg;
      logic [63:0] sr_lo;
      logic [63:0] sr_hi;
      logic [63:0] ny_lo;
      logic [63:0] ny_hi;
      logic [63:0] nx_lo;
      logic [63:0] nx_hi;
   } mul_type;

   typedef struct packed {
      logic [31:0] r;
      logic [63:0] s;
      logic [31:0] apx;
      logic [31:0] apy;
      logic [5:0]  neg;
      logic [95:0] den3;
      logic [95:0] ny;
      logic [95:0] nx;
   } sum_type;

   logic [LAT-1:0] vld_ff;
   logic           fin_vld_ff;
   logic           adv;
   ctx_type        b0_ff, b0_in;
   logic [63:0]    v_ff   [SQ_STAGES-1];
   logic [63:0]    res_ff [SQ_STAGES];
   ctx_type        ctx_ff [SQ_STAGES];
   logic [63:0]    v_src   [SQ_STAGES];
   logic [63:0]    res_src [SQ_STAGES];
   ctx_type        ctx_src [SQ_STAGES];
   mul_type        m1_ff, m1_in;
   sum_type        m2_ff, m2_in;
   logic [5:0]     neg_ff [DIV_STAGES];
   logic [RMJ_QUO_W-1:0] quo [6];
   logic [5:0]     ovf;
   result_type     fin_ff, fin_in;

   logic [63:0]          sum_sq, floor_sq;
   logic [RMJ_CSR_W-1:0] floor_val;
   logic                 a_ge;

   // whole back pipeline moves together unless the result word is stuck
   assign adv      = !fin_vld_ff || !res_full;
   assign q_pop    = adv && !q_empty;
   assign res_push = fin_vld_ff && !res_full;
   assign res_word = fin_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff     <= '0;
         fin_vld_ff <= 1'b0;
      end else if (adv) begin
         vld_ff     <= {vld_ff[LAT-2:0], !q_empty};
         fin_vld_ff <= vld_ff[LAT-1];
      end
   end

   // squared range with floor, velocity cross term and result signs
   always_comb begin
      sum_sq    = q_word.px2 + q_word.py2;
      floor_val = (min_range_sq == '0) ? RMJ_CSR_W'(1) : min_range_sq;
      floor_sq  = 64'(floor_val) << FRACTION_BITS;
      a_ge      = (q_word.prod_a >= q_word.prod_b);
      b0_in.s    = (sum_sq < floor_sq) ? floor_sq : sum_sq;
      b0_in.dmag = a_ge ? 64'(q_word.prod_a - q_word.prod_b)
                        : 64'(q_word.prod_b - q_word.prod_a);
      b0_in.apx  = q_word.apx;
      b0_in.apy  = q_word.apy;
      b0_in.neg[0] = q_word.px_neg;
      b0_in.neg[1] = q_word.py_neg;
      b0_in.neg[2] = q_word.py_pos;
      b0_in.neg[3] = q_word.px_neg;
      b0_in.neg[4] = (b0_in.dmag != '0) && (q_word.apy != '0) && (q_word.py_neg != !a_ge);
      b0_in.neg[5] = (b0_in.dmag != '0) && (q_word.apx != '0) && (q_word.px_neg == !a_ge);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         b0_ff <= b0_in;
      end
   end

   // square root, one result bit per stage
   assign v_src[0]   = b0_ff.s;
   assign res_src[0] = '0;
   assign ctx_src[0] = b0_ff;

   for (genvar k = 0; k < SQ_STAGES; k++) begin : g_sqrt
      localparam logic [63:0] BIT = 64'(1) << (62 - 2 * k);
      logic [63:0] trial;
      logic        take;
      logic [63:0] res_in;

      if (k > 0) begin : g_link
         assign v_src[k]   = v_ff[k-1];
         assign res_src[k] = res_ff[k-1];
         assign ctx_src[k] = ctx_ff[k-1];
      end

      assign trial  = res_src[k] + BIT;
      assign take   = (v_src[k] >= trial);
      assign res_in = take ? ((res_src[k] >> 1) + BIT) : (res_src[k] >> 1);

      always_ff @(posedge clock) begin
         if (adv) begin
            res_ff[k] <= res_in;
            ctx_ff[k] <= ctx_src[k];
         end
      end

      if (k < SQ_STAGES - 1) begin : g_rest
         logic [63:0] v_in;
         assign v_in = take ? (v_src[k] - trial) : v_src[k];
         always_ff @(posedge clock) begin
            if (adv) begin
               v_ff[k] <= v_in;
            end
         end
      end
   end

   // partial products for r^3 and the rate numerators
   always_comb begin
      m1_in.r     = res_ff[SQ_STAGES-1][31:0];
      m1_in.s     = ctx_ff[SQ_STAGES-1].s;
      m1_in.apx   = ctx_ff[SQ_STAGES-1].apx;
      m1_in.apy   = ctx_ff[SQ_STAGES-1].apy;
      m1_in.neg   = ctx_ff[SQ_STAGES-1].neg;
      m1_in.sr_lo = 64'(m1_in.s[31:0]) * 64'(m1_in.r);
      m1_in.sr_hi = 64'(m1_in.s[63:32]) * 64'(m1_in.r);
      m1_in.ny_lo = 64'(m1_in.apy) * 64'(ctx_ff[SQ_STAGES-1].dmag[31:0]);
      m1_in.ny_hi = 64'(m1_in.apy) * 64'(ctx_ff[SQ_STAGES-1].dmag[63:32]);
      m1_in.nx_lo = 64'(m1_in.apx) * 64'(ctx_ff[SQ_STAGES-1].dmag[31:0]);
      m1_in.nx_hi = 64'(m1_in.apx) * 64'(ctx_ff[SQ_STAGES-1].dmag[63:32]);
   end

   // partial product sums
   always_comb begin
      m2_in.r    = m1_ff.r;
      m2_in.s    = m1_ff.s;
      m2_in.apx  = m1_ff.apx;
      m2_in.apy  = m1_ff.apy;
      m2_in.neg  = m1_ff.neg;
      m2_in.den3 = {32'd0, m1_ff.sr_lo} + {m1_ff.sr_hi, 32'd0};
      m2_in.ny   = {32'd0, m1_ff.ny_lo} + {m1_ff.ny_hi, 32'd0};
      m2_in.nx   = {32'd0, m1_ff.nx_lo} + {m1_ff.nx_hi, 32'd0};
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         m1_ff <= m1_in;
         m2_ff <= m2_in;
      end
   end

   // six quotients in parallel
   rmj_div #(.NUM_W(32 + FRACTION_BITS), .DEN_W(32)) u_div_range_x (
      .clock(clock), .enable(adv),
      .num({m2_ff.apx, {FRACTION_BITS{1'b0}}}), .den(m2_ff.r),
      .quo(quo[0]), .ovf(ovf[0]));

   rmj_div #(.NUM_W(32 + FRACTION_BITS), .DEN_W(32)) u_div_range_y (
      .clock(clock), .enable(adv),
      .num({m2_ff.apy, {FRACTION_BITS{1'b0}}}), .den(m2_ff.r),
      .quo(quo[1]), .ovf(ovf[1]));

   rmj_div #(.NUM_W(32 + 2 * FRACTION_BITS), .DEN_W(64)) u_div_bearing_x (
      .clock(clock), .enable(adv),
      .num({m2_ff.apy, {(2 * FRACTION_BITS){1'b0}}}), .den(m2_ff.s),
      .quo(quo[2]), .ovf(ovf[2]));

   rmj_div #(.NUM_W(32 + 2 * FRACTION_BITS), .DEN_W(64)) u_div_bearing_y (
      .clock(clock), .enable(adv),
      .num({m2_ff.apx, {(2 * FRACTION_BITS){1'b0}}}), .den(m2_ff.s),
      .quo(quo[3]), .ovf(ovf[3]));

   rmj_div #(.NUM_W(96 + FRACTION_BITS), .DEN_W(96)) u_div_rate_x (
      .clock(clock), .enable(adv),
      .num({m2_ff.ny, {FRACTION_BITS{1'b0}}}), .den(m2_ff.den3),
      .quo(quo[4]), .ovf(ovf[4]));

   rmj_div #(.NUM_W(96 + FRACTION_BITS), .DEN_W(96)) u_div_rate_y (
      .clock(clock), .enable(adv),
      .num({m2_ff.nx, {FRACTION_BITS{1'b0}}}), .den(m2_ff.den3),
      .quo(quo[5]), .ovf(ovf[5]));

   // signs ride alongside the dividers
   always_ff @(posedge clock) begin
      if (adv) begin
         neg_ff[0] <= m2_ff.neg;
         for (int i = 1; i < DIV_STAGES; i++) begin
            neg_ff[i] <= neg_ff[i-1];
         end
      end
   end

   // apply sign and clip, flag in the top bit
   function automatic logic [32:0] clip(input logic [31:0] mag, input logic over,
                                        input logic neg);
      logic        sat;
      logic [31:0] val;
      if (neg) begin
         sat = over || (mag > 32'h8000_0000);
         val = sat ? 32'h8000_0000 : (~mag + 32'd1);
      end else begin
         sat = over || mag[31];
         val = sat ? 32'h7fff_ffff : mag;
      end
      return {sat, val};
   endfunction

   always_comb begin
      logic [32:0] c [6];
      for (int i = 0; i < 6; i++) begin
         c[i] = clip(quo[i], ovf[i], neg_ff[DIV_STAGES-1][i]);
      end
      fin_in.range_by_px   = c[0][31:0];
      fin_in.range_by_py   = c[1][31:0];
      fin_in.bearing_by_px = c[2][31:0];
      fin_in.bearing_by_py = c[3][31:0];
      fin_in.rate_by_px    = c[4][31:0];
      fin_in.rate_by_py    = c[5][31:0];
      fin_in.saturated     = c[0][32] | c[1][32] | c[2][32] | c[3][32] | c[4][32] | c[5][32];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         fin_ff <= fin_in;
      end
   end

   // checks
   `RMJ_ASSERT_NEXT(a_fin_hold, fin_vld_ff && res_full, fin_vld_ff && $stable(fin_ff),
                    "result word changed while stalled")
   `RMJ_ASSERT_NEXT(a_pop_enters, q_pop, vld_ff[0], "popped word missing from first stage")
   `RMJ_ASSERT_NEXT(a_fin_follows, adv && vld_ff[LAT-1], fin_vld_ff,
                    "last stage word did not reach the result register")
   `RMJ_ASSERT_NEXT(a_stall_freezes, !adv, $stable(vld_ff), "pipeline moved while stalled")
   `RMJ_ASSERT_IMP(a_push_moves, res_push, adv, "result pushed without pipeline advance")

endmodule

// ===== hw/rtl/radar_measurement_jacobian.sv =====
// channel   ports                      handshake
// -------   -------------------------  ----------------------------------
// request   req_pos_x/y, req_vel_x/y   word taken when req_push && !req_full
// response  rsp_* six entries, flag    word taken when rsp_pop && !rsp_empty
// control   csr_wdata                  written when csr_we
//
// one word per cycle sustained unless the response stalls; words pass the
// front register, middle queue, 32-stage square root, 33-stage dividers
// and response queue. reset is synchronous, active high, and clears all
// queues and valid bits. a stalled response freezes the back pipeline;
// the front keeps taking words until the queue between the two fills.
module radar_measurement_jacobian import rmj_pkg::*; #(
   parameter int FRACTION_BITS = RMJ_FRACTION_BITS,
   parameter int QUEUE_DEPTH   = RMJ_QUEUE_DEPTH
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_push,
   input  logic signed [31:0]   req_pos_x,
   input  logic signed [31:0]   req_pos_y,
   input  logic signed [31:0]   req_vel_x,
   input  logic signed [31:0]   req_vel_y,
   output logic                 req_full,
   output logic                 rsp_empty,
   input  logic                 rsp_pop,
   output logic signed [31:0]   rsp_range_by_px,
   output logic signed [31:0]   rsp_range_by_py,
   output logic signed [31:0]   rsp_bearing_by_px,
   output logic signed [31:0]   rsp_bearing_by_py,
   output logic signed [31:0]   rsp_rate_by_px,
   output logic signed [31:0]   rsp_rate_by_py,
   output logic                 rsp_saturated,
   input  logic                 csr_we,
   input  logic [RMJ_CSR_W-1:0] csr_wdata
);

   logic [RMJ_CSR_W-1:0] min_range_sq_ff;
   front_type            fq_wr, fq_rd;
   logic                 fq_push, fq_full, fq_pop, fq_empty;
   result_type           rq_wr, rq_rd;
   logic                 rq_push, rq_full;

   // range floor register
   always_ff @(posedge clock) begin
      if (reset) begin
         min_range_sq_ff <= RMJ_MIN_RANGE_SQ_RESET;
      end else if (csr_we) begin
         min_range_sq_ff <= csr_wdata;
      end
   end

   rmj_front u_front (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_pos_x(req_pos_x), .req_pos_y(req_pos_y),
      .req_vel_x(req_vel_x), .req_vel_y(req_vel_y), .req_full(req_full),
      .q_word(fq_wr), .q_push(fq_push), .q_full(fq_full));

   rmj_queue #(.WIDTH($bits(front_type)), .DEPTH(QUEUE_DEPTH)) u_mid_queue (
      .clock(clock), .reset(reset),
      .push(fq_push), .wdata(fq_wr), .full(fq_full),
      .pop(fq_pop), .rdata(fq_rd), .empty(fq_empty));

   rmj_back #(.FRACTION_BITS(FRACTION_BITS)) u_back (
      .clock(clock), .reset(reset), .min_range_sq(min_range_sq_ff),
      .q_word(fq_rd), .q_empty(fq_empty), .q_pop(fq_pop),
      .res_word(rq_wr), .res_push(rq_push), .res_full(rq_full));

   rmj_queue #(.WIDTH($bits(result_type)), .DEPTH(QUEUE_DEPTH)) u_rsp_queue (
      .clock(clock), .reset(reset),
      .push(rq_push), .wdata(rq_wr), .full(rq_full),
      .pop(rsp_pop), .rdata(rq_rd), .empty(rsp_empty));

   // response fields
   assign rsp_range_by_px   = rq_rd.range_by_px;
   assign rsp_range_by_py   = rq_rd.range_by_py;
   assign rsp_bearing_by_px = rq_rd.bearing_by_px;
   assign rsp_bearing_by_py = rq_rd.bearing_by_py;
   assign rsp_rate_by_px    = rq_rd.rate_by_px;
   assign rsp_rate_by_py    = rq_rd.rate_by_py;
   assign rsp_saturated     = rq_rd.saturated;

endmodule

// ===== bench/rmj_checker.sv =====
`timescale 1ns / 100ps

// watches both channels, predicts each jacobian word and compares in order
module rmj_checker import rmj_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_push,
   input  logic                 req_full,
   input  logic signed [31:0]   req_pos_x,
   input  logic signed [31:0]   req_pos_y,
   input  logic signed [31:0]   req_vel_x,
   input  logic signed [31:0]   req_vel_y,
   input  logic                 rsp_empty,
   input  logic                 rsp_pop,
   input  logic signed [31:0]   rsp_range_by_px,
   input  logic signed [31:0]   rsp_range_by_py,
   input  logic signed [31:0]   rsp_bearing_by_px,
   input  logic signed [31:0]   rsp_bearing_by_py,
   input  logic signed [31:0]   rsp_rate_by_px,
   input  logic signed [31:0]   rsp_rate_by_py,
   input  logic                 rsp_saturated,
   input  logic                 csr_we,
   input  logic [RMJ_CSR_W-1:0] csr_wdata,
   output int                   fail_count,
   output int                   pending_count
);

   localparam int FB = RMJ_FRACTION_BITS;

   result_type             jacobian_queue[$];
   logic [RMJ_CSR_W-1:0]   range_floor;

   // integer square root, floor
   function automatic logic [63:0] isqrt(input logic [63:0] v);
      logic [63:0] res;
      logic [63:0] bitv;
      res  = '0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v   = v - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   // apply sign to magnitude quotient and clip to 32 bits
   function automatic logic signed [31:0] clip_q(input logic [191:0] mag, input logic neg,
                                                 inout logic sat);
      if (neg) begin
         if (mag > 192'h8000_0000) begin
            sat = 1'b1;
            return 32'sh8000_0000;
         end
         return -mag[31:0];
      end
      if (mag > 192'h7FFF_FFFF) begin
         sat = 1'b1;
         return 32'sh7FFF_FFFF;
      end
      return mag[31:0];
   endfunction

   function automatic result_type jacobian_of(input logic signed [31:0] px,
                                              input logic signed [31:0] py,
                                              input logic signed [31:0] vx,
                                              input logic signed [31:0] vy,
                                              input logic [RMJ_CSR_W-1:0] fl);
      result_type         o;
      logic [63:0]        apx, apy, s, r, flv, dmag;
      logic signed [63:0] a, b;
      logic               dneg, sat;
      logic [191:0]       den;
      apx = px < 0 ? -64'(px) : 64'(px);
      apy = py < 0 ? -64'(py) : 64'(py);
      flv = (fl == 0) ? 64'd1 : 64'(fl);
      flv = flv << FB;
      s   = apx * apx + apy * apy;
      if (s < flv) s = flv;
      r   = isqrt(s);
      sat = 1'b0;
      o.range_by_px   = clip_q((192'(apx) << FB) / 192'(r), px < 0, sat);
      o.range_by_py   = clip_q((192'(apy) << FB) / 192'(r), py < 0, sat);
      o.bearing_by_px = clip_q((192'(apy) << (2 * FB)) / 192'(s), py > 0, sat);
      o.bearing_by_py = clip_q((192'(apx) << (2 * FB)) / 192'(s), px < 0, sat);
      a = 64'(vx) * 64'(py);
      b = 64'(vy) * 64'(px);
      if (a >= b) begin
         dmag = a - b;
         dneg = 1'b0;
      end else begin
         dmag = b - a;
         dneg = 1'b1;
      end
      den = 192'(s) * 192'(r);
      o.rate_by_px = clip_q(((192'(apy) * 192'(dmag)) << FB) / den,
                            dmag != 0 && apy != 0 && ((py < 0) != dneg), sat);
      o.rate_by_py = clip_q(((192'(apx) * 192'(dmag)) << FB) / den,
                            dmag != 0 && apx != 0 && ((px < 0) == dneg), sat);
      o.saturated  = sat;
      return o;
   endfunction

   task automatic report_mismatch(input string field, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch %s: got %h want %h at %0t", field, got, want, $time);
      fail_count++;
   endtask

   // track register, predict on push, compare on pop
   always @(posedge clock) begin
      result_type want;
      if (reset) begin
         range_floor <= RMJ_MIN_RANGE_SQ_RESET;
         jacobian_queue.delete();
      end else begin
         if (csr_we) range_floor <= csr_wdata;
         if (req_push && !req_full)
            jacobian_queue.push_back(jacobian_of(req_pos_x, req_pos_y, req_vel_x,
                                                 req_vel_y, range_floor));
         if (rsp_pop && !rsp_empty) begin
            if (jacobian_queue.size() == 0) begin
               $display("unexpected word at %0t", $time);
               fail_count++;
            end else begin
               want = jacobian_queue.pop_front();
               if (rsp_range_by_px !== want.range_by_px)
                  report_mismatch("range_by_px", rsp_range_by_px, want.range_by_px);
               if (rsp_range_by_py !== want.range_by_py)
                  report_mismatch("range_by_py", rsp_range_by_py, want.range_by_py);
               if (rsp_bearing_by_px !== want.bearing_by_px)
                  report_mismatch("bearing_by_px", rsp_bearing_by_px, want.bearing_by_px);
               if (rsp_bearing_by_py !== want.bearing_by_py)
                  report_mismatch("bearing_by_py", rsp_bearing_by_py, want.bearing_by_py);
               if (rsp_rate_by_px !== want.rate_by_px)
                  report_mismatch("rate_by_px", rsp_rate_by_px, want.rate_by_px);
               if (rsp_rate_by_py !== want.rate_by_py)
                  report_mismatch("rate_by_py", rsp_rate_by_py, want.rate_by_py);
               if (rsp_saturated !== want.saturated)
                  report_mismatch("saturated", 32'(rsp_saturated), 32'(want.saturated));
            end
         end
      end
   end

   initial fail_count = 0;
   assign pending_count = jacobian_queue.size();

endmodule

// ===== bench/tb_radar_measurement_jacobian.sv =====
`timescale 1ns / 100ps

module tb_radar_measurement_jacobian;
   import rmj_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int DRAIN_CYCLES   = 200;

   logic                 clock;
   logic                 reset;
   logic                 req_push;
   logic signed [31:0]   req_pos_x, req_pos_y, req_vel_x, req_vel_y;
   logic                 req_full;
   logic                 rsp_empty;
   logic                 rsp_pop;
   logic signed [31:0]   rsp_range_by_px, rsp_range_by_py;
   logic signed [31:0]   rsp_bearing_by_px, rsp_bearing_by_py;
   logic signed [31:0]   rsp_rate_by_px, rsp_rate_by_py;
   logic                 rsp_saturated;
   logic                 csr_we;
   logic [RMJ_CSR_W-1:0] csr_wdata;
   int                   fail_count, pending_count;
   int                   idle_cycles;
   logic                 stall_mode;

   radar_measurement_jacobian u_top (.*);

   rmj_checker u_checker (.*);

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // receiver stall pattern: alternating free and choppy stretches
   always @(posedge clock) begin
      if (reset) begin
         rsp_pop    <= 1'b0;
         stall_mode <= 1'b0;
      end else begin
         if ($urandom_range(0, 199) == 0) stall_mode <= ~stall_mode;
         rsp_pop <= stall_mode ? ($urandom_range(0, 3) == 0) : 1'b1;
      end
   end

   // watchdog on cycles with no accepted word
   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // one word, held until accepted
   task automatic send_word(input logic [31:0] px, input logic [31:0] py,
                            input logic [31:0] vx, input logic [31:0] vy);
      req_push  <= 1'b1;
      req_pos_x <= px;
      req_pos_y <= py;
      req_vel_x <= vx;
      req_vel_y <= vy;
      @(posedge clock);
      while (req_full) @(posedge clock);
   endtask

   task automatic pause_sender(input int n);
      req_push <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   task automatic drain_and_write(input logic [RMJ_CSR_W-1:0] v);
      req_push <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   function automatic logic [31:0] rand_field();
      case ($urandom_range(0, 5))
         0: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
         1: return 32'($signed($urandom_range(0, 8191)) - 4096);
         2: return 32'($signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000);
         default: return $urandom;
      endcase
   endfunction

   initial begin
      logic [RMJ_CSR_W-1:0] floors[5];
      int                   burst;
      floors = '{17'd0, 17'd1, 17'd65536, 17'h1FFFF, 17'd4096};
      reset     <= 1'b1;
      req_push  <= 1'b0;
      req_pos_x <= '0;
      req_pos_y <= '0;
      req_vel_x <= '0;
      req_vel_y <= '0;
      csr_we    <= 1'b0;
      csr_wdata <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: zero state below floor, extremes, signs, saturation
      send_word(0, 0, 0, 0);
      send_word(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      send_word(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      send_word(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
      send_word(32'h0001_0000, 0, 0, 32'h0001_0000);
      send_word(0, 32'hFFFF_0000, 32'h0001_0000, 0);
      send_word(1, 1, 32'h7FFF_FFFF, 32'h8000_0000);
      send_word(32'hFFFF_FFFF, 1, 32'h8000_0000, 32'h7FFF_FFFF);
      send_word(32'h0003_0000, 32'h0004_0000, 32'hFFFE_0000, 32'h0001_8000);
      send_word(32'hFFFD_0000, 32'hFFFC_0000, 32'h0002_0000, 32'hFFFF_0000);
      send_word(8, 0, 32'h0100_0000, 32'h0100_0000);

      // five register settings, extremes included, each followed by two directed words, then random words
      for (int ph = 0; ph < 5; ph++) begin
         drain_and_write(floors[ph]);
         send_word(0, 1, 32'h8000_0000, 32'h7FFF_FFFF);
         send_word(32'h0000_0100, 32'hFFFF_FF00, $urandom, $urandom);
         for (int n = 0; n < 265; ) begin
            burst = $urandom_range(1, 30);
            for (int k = 0; k < burst; k++, n++)
               send_word(rand_field(), rand_field(), rand_field(), rand_field());
            if ($urandom_range(0, 2) != 0) pause_sender($urandom_range(1, 12));
         end
      end

      req_push <= 1'b0;
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/rmj_pkg.sv
hw/rtl/rmj_queue.sv
hw/rtl/rmj_front.sv
hw/rtl/rmj_div.sv
hw/rtl/rmj_back.sv
hw/rtl/radar_measurement_jacobian.sv
bench/rmj_checker.sv
bench/tb_radar_measurement_jacobian.sv
